// ===== hdl/tmq_pkg.sv =====
// ----------------------------------------------------------------------------
// tmq_pkg
// Types and constants shared by the typed message queue and its cells.
// ----------------------------------------------------------------------------
package tmq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int TYPE_W    = 31;
    localparam int LENGTH_W  = 10;
    localparam int PAYLOAD_W = 64;
    localparam int WANT_W    = 32;
    localparam int STATUS_W  = 2;

    localparam logic CMD_SEND = 1'b0;
    localparam logic CMD_RECV = 1'b1;

    localparam logic [STATUS_W-1:0] ST_STORED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RECEIVED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOMATCH  = 2'd3;

    typedef struct packed {
        logic                        cmd;
        logic [TYPE_W-1:0]           msg_type;
        logic [LENGTH_W-1:0]         msg_length;
        logic [PAYLOAD_W-1:0]        msg_payload;
        logic signed [WANT_W-1:0]    want_type;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [TYPE_W-1:0]    got_type;
        logic [LENGTH_W-1:0]  got_length;
        logic [PAYLOAD_W-1:0] got_payload;
    } t_rsp;

    typedef struct packed {
        logic [TYPE_W-1:0]    msg_type;
        logic [LENGTH_W-1:0]  msg_length;
        logic [PAYLOAD_W-1:0] msg_payload;
    } t_slot;

    typedef struct packed {
        logic               send_go;
        logic               recv_go;
        logic               want_neg;
        logic [WANT_W-1:0]  want_val;
        t_slot              new_slot;
    } t_cell_ctl;

    typedef struct packed {
        logic  found;
        t_slot data;
    } t_chain;

endpackage

// ===== hdl/tmq_cell.sv =====
// ----------------------------------------------------------------------------
// tmq_cell
// One queue slot: stores a message, tests it against the wanted type, passes
// the first-match token and the taken message down the row, and closes up
// over a removed slot by taking its neighbour's contents.
// ----------------------------------------------------------------------------
module tmq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tmq_pkg::t_cell_ctl i_ctl,
    input  logic               i_prev_valid,
    input  logic               i_next_valid,
    input  tmq_pkg::t_slot     i_next_slot,
    input  tmq_pkg::t_chain    i_chain,
    output logic               o_valid,
    output tmq_pkg::t_slot     o_slot,
    output tmq_pkg::t_chain    o_chain
);
    import tmq_pkg::*;

    logic         r_valid;
    logic         n_valid;
    t_slot        r_slot;
    t_slot        n_slot;
    logic [WANT_W-1:0] type_ext;
    logic         hit;
    logic         take;
    t_slot        take_data;

    assign type_ext = {1'b0, r_slot.msg_type};

    always_comb begin
        if (i_ctl.want_neg) begin
            hit = r_valid && (type_ext <= i_ctl.want_val);
        end else begin
            hit = r_valid && (type_ext == i_ctl.want_val);
        end
    end

    assign take      = hit && !i_chain.found;
    assign take_data = take ? r_slot : '0;

    always_comb begin
        o_chain.found            = i_chain.found || hit;
        o_chain.data.msg_type    = i_chain.data.msg_type    | take_data.msg_type;
        o_chain.data.msg_length  = i_chain.data.msg_length  | take_data.msg_length;
        o_chain.data.msg_payload = i_chain.data.msg_payload | take_data.msg_payload;
    end

    always_comb begin
        n_valid = r_valid;
        n_slot  = r_slot;
        if (i_ctl.send_go && !r_valid && i_prev_valid) begin
            n_valid = 1'b1;
            n_slot  = i_ctl.new_slot;
        end else if (i_ctl.recv_go && o_chain.found) begin
            n_valid = i_next_valid;
            n_slot  = i_next_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_slot <= n_slot;
    end

    assign o_valid = r_valid;
    assign o_slot  = r_slot;

endmodule

// ===== hdl/typed_message_queue.sv =====
// ----------------------------------------------------------------------------
// typed_message_queue
// Mailbox of typed messages kept oldest first in a row of cells, with send
// and selective receive; a removed message is closed up over in order.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  req     | in        | i_req_valid / o_req_ready  | i_req (t_req)
//  rsp     | out       | o_rsp_valid / i_rsp_ready  | o_rsp (t_rsp)
//
//  Each transaction is first registered; then, in the work state, every
//  cell compares, the first-match token ripples along the row of
//  QUEUE_DEPTH cells and the row shifts or appends.
//  The response is held in an output register; a new request is taken while
//  it waits, and the work cycle waits only until that register is free.
//  Synchronous reset empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
module typed_message_queue #(
    parameter int QUEUE_DEPTH = tmq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  tmq_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output tmq_pkg::t_rsp o_rsp
);
    import tmq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state    r_state;
    t_state    n_state;
    t_req      r_req;
    logic      r_rsp_valid;
    logic      n_rsp_valid;
    t_rsp      r_rsp;
    t_rsp      n_rsp;
    logic      exec;
    t_cell_ctl ctl;

    logic   cell_valid [QUEUE_DEPTH];
    t_slot  cell_slot  [QUEUE_DEPTH];
    t_chain chain      [QUEUE_DEPTH+1];

    assign o_req_ready = (r_state == S_IDLE);
    assign exec        = (r_state == S_EXEC) && (!r_rsp_valid || i_rsp_ready);

    always_comb begin
        ctl.send_go           = exec && (r_req.cmd == CMD_SEND);
        ctl.recv_go           = exec && (r_req.cmd == CMD_RECV);
        ctl.want_neg          = r_req.want_type[WANT_W-1];
        ctl.want_val          = ctl.want_neg ? WANT_W'(-r_req.want_type)
                                             : WANT_W'(r_req.want_type);
        ctl.new_slot.msg_type    = r_req.msg_type;
        ctl.new_slot.msg_length  = r_req.msg_length;
        ctl.new_slot.msg_payload = r_req.msg_payload;
    end

    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic  prev_valid;
            logic  next_valid;
            t_slot next_slot;
            if (g == 0) begin : g_first
                assign prev_valid = 1'b1;
            end else begin : g_mid
                assign prev_valid = cell_valid[g-1];
            end
            if (g == QUEUE_DEPTH-1) begin : g_last
                assign next_valid = 1'b0;
                assign next_slot  = '0;
            end else begin : g_inner
                assign next_valid = cell_valid[g+1];
                assign next_slot  = cell_slot[g+1];
            end
            tmq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (ctl),
                .i_prev_valid (prev_valid),
                .i_next_valid (next_valid),
                .i_next_slot  (next_slot),
                .i_chain      (chain[g]),
                .o_valid      (cell_valid[g]),
                .o_slot       (cell_slot[g]),
                .o_chain      (chain[g+1])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_rsp_valid = r_rsp_valid;
        n_rsp       = r_rsp;
        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec) begin
                    n_state     = S_IDLE;
                    n_rsp_valid = 1'b1;
                    n_rsp       = '0;
                    if (r_req.cmd == CMD_SEND) begin
                        n_rsp.status = cell_valid[QUEUE_DEPTH-1] ? ST_DROPPED : ST_STORED;
                    end else if (chain[QUEUE_DEPTH].found) begin
                        n_rsp.status      = ST_RECEIVED;
                        n_rsp.got_type    = chain[QUEUE_DEPTH].data.msg_type;
                        n_rsp.got_length  = chain[QUEUE_DEPTH].data.msg_length;
                        n_rsp.got_payload = chain[QUEUE_DEPTH].data.msg_payload;
                    end else begin
                        n_rsp.status = ST_NOMATCH;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
        r_rsp <= n_rsp;
        if (i_req_valid && o_req_ready) begin
            r_req <= i_req;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

// ===== hdl/tmq_checker.sv =====
// ----------------------------------------------------------------------------
// tmq_port_checks
// Port-level checks for the typed message queue, bound to the top level.
// ----------------------------------------------------------------------------
module tmq_port_checks (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          o_req_ready,
    input logic          o_rsp_valid,
    input logic          i_rsp_ready,
    input tmq_pkg::t_rsp o_rsp
);
    import tmq_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("response changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid && o_req_ready)
        else $error("response or busy state survives reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("second transaction taken during work cycle");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status != ST_RECEIVED)
        |-> (o_rsp.got_type == '0) && (o_rsp.got_length == '0)
            && (o_rsp.got_payload == '0))
        else $error("non-receive response carries message fields");

endmodule

bind typed_message_queue tmq_port_checks u_tmq_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);
